[hdl/gpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO controller package
// Shared widths, codes and interface structs of the pin-interrupt GPIO port.
// ----------------------------------------------------------------------------
package gpc_pkg;

   localparam int PORT_W            = 32;
   localparam int HALF_PINS         = 16;
   localparam int PIN_IDX_W         = 5;
   localparam int PIN_COUNT_DEFAULT = 32;
   localparam int CSR_IDX_W         = 3;
   localparam int MODE_W            = 2;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_TICK  = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      SEL_DATA   = 3'd0,
      SEL_SET    = 3'd1,
      SEL_CLEAR  = 3'd2,
      SEL_TOGGLE = 3'd3,
      SEL_IRQ_EN = 3'd4,
      SEL_STATUS = 3'd5
   } reg_sel_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIRECTION = 3'd0,
      CSR_MODE_LOW  = 3'd1,
      CSR_MODE_HIGH = 3'd2,
      CSR_ANY_EDGE  = 3'd3
   } csr_idx_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOW_LEVEL  = 2'd0,
      MODE_HIGH_LEVEL = 2'd1,
      MODE_RISING     = 2'd2,
      MODE_FALLING    = 2'd3
   } irq_mode_type;

   // Per-pin slice of an accepted request
   typedef struct packed {
      logic        accept;
      action_type  action;
      reg_sel_type sel;
      logic        wdata;
      logic        pad;
   } pin_req_type;

   // Per-pin slice of a configuration write
   typedef struct packed {
      logic                  we;
      logic [CSR_IDX_W-1:0]  index;
      logic                  bit_data;
      logic [MODE_W-1:0]     mode_data;
   } pin_csr_type;

   // Per-pin state seen by the port logic
   typedef struct packed {
      logic latch;
      logic dir;
      logic data_rd;
      logic enable;
      logic status;
      logic pend;
      logic is_first;
   } pin_stat_type;

endpackage

[hdl/gpc_pin_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO pin cell
// Holds one pin's configuration, latch, enable, status and last pad sample,
// and passes the pending-search carry on to the next pin up.
// ----------------------------------------------------------------------------
module gpc_pin_cell #(
   parameter int PIN_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gpc_pkg::pin_req_type  req,
   input  gpc_pkg::pin_csr_type  csr,
   input  logic                  found_in,
   output logic                  found_out,
   output gpc_pkg::pin_stat_type stat
);

   localparam logic [gpc_pkg::CSR_IDX_W-1:0] MODE_REG =
      (PIN_INDEX < gpc_pkg::HALF_PINS) ? gpc_pkg::CSR_MODE_LOW : gpc_pkg::CSR_MODE_HIGH;

   logic                      dir_ff, dir_in;
   logic                      any_ff, any_in;
   logic [gpc_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic                      latch_ff, latch_in;
   logic                      enable_ff, enable_in;
   logic                      status_ff, status_in;
   logic                      prev_ff, prev_in;
   logic                      hit;
   logic                      pend;

   always_comb begin
      dir_in  = dir_ff;
      any_in  = any_ff;
      mode_in = mode_ff;
      if (csr.we) begin
         if (csr.index == gpc_pkg::CSR_DIRECTION) begin
            dir_in = csr.bit_data;
         end
         if (csr.index == gpc_pkg::CSR_ANY_EDGE) begin
            any_in = csr.bit_data;
         end
         if (csr.index == MODE_REG) begin
            mode_in = csr.mode_data;
         end
      end
   end

   // Condition of this pin against the previous sample
   always_comb begin
      if (any_ff) begin
         hit = req.pad ^ prev_ff;
      end else begin
         case (gpc_pkg::irq_mode_type'(mode_ff))
            gpc_pkg::MODE_LOW_LEVEL:  hit = ~req.pad;
            gpc_pkg::MODE_HIGH_LEVEL: hit = req.pad;
            gpc_pkg::MODE_RISING:     hit = ~prev_ff & req.pad;
            gpc_pkg::MODE_FALLING:    hit = prev_ff & ~req.pad;
            default:                  hit = 1'b0;
         endcase
      end
   end

   always_comb begin
      latch_in  = latch_ff;
      enable_in = enable_ff;
      status_in = status_ff;
      prev_in   = prev_ff;
      if (req.accept) begin
         case (req.action)
            gpc_pkg::ACT_WRITE: begin
               case (req.sel)
                  gpc_pkg::SEL_DATA:   latch_in  = req.wdata;
                  gpc_pkg::SEL_SET:    latch_in  = latch_ff | req.wdata;
                  gpc_pkg::SEL_CLEAR:  latch_in  = latch_ff & ~req.wdata;
                  gpc_pkg::SEL_TOGGLE: latch_in  = latch_ff ^ req.wdata;
                  gpc_pkg::SEL_IRQ_EN: enable_in = req.wdata;
                  gpc_pkg::SEL_STATUS: status_in = status_ff & ~req.wdata;
                  default: ;
               endcase
            end
            gpc_pkg::ACT_TICK: begin
               status_in = status_ff | hit;
               prev_in   = req.pad;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff    <= 1'b0;
         any_ff    <= 1'b0;
         mode_ff   <= '0;
         latch_ff  <= 1'b0;
         enable_ff <= 1'b0;
         status_ff <= 1'b0;
         prev_ff   <= 1'b0;
      end else begin
         dir_ff    <= dir_in;
         any_ff    <= any_in;
         mode_ff   <= mode_in;
         latch_ff  <= latch_in;
         enable_ff <= enable_in;
         status_ff <= status_in;
         prev_ff   <= prev_in;
      end
   end

   assign pend      = status_ff & enable_ff;
   assign found_out = found_in | pend;

   assign stat.latch    = latch_ff;
   assign stat.dir      = dir_ff;
   assign stat.data_rd  = dir_ff ? latch_ff : prev_ff;
   assign stat.enable   = enable_ff;
   assign stat.status   = status_ff;
   assign stat.pend     = pend;
   assign stat.is_first = pend & ~found_in;

endmodule

[hdl/gpio_port_with_pin_interrupts_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO port with pin interrupts
// A row of pin cells with a registered response stage.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one bus read, bus write or pad-sample tick per request;
//   it is taken at a clock edge with req_valid high and req_stall low.
//   rsp_* returns one response per request: read data, pad drive signals,
//   the two half-port interrupt lines and the lowest enabled pending pin,
//   all as they stand after the request has taken effect.
//   csr_* writes direction, mode and any-edge registers; write it only
//   while no response is outstanding.
// Response: registered, and valid in the cycle after the request is taken.
// Flow: one request per cycle while req_stall is low; the pin cells update
//   on accept and the response register frees up in the cycle it is taken.
// Stall: while rsp_stall holds a response, req_stall is raised and the
//   response and pin state hold.
// Reset: clears every pin cell's configuration, latch, enable, status and
//   pad sample and empties the response stage, but not the read data.
// ----------------------------------------------------------------------------
module gpio_port_with_pin_interrupts_top #(
   parameter int PIN_COUNT = gpc_pkg::PIN_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_action,
   input  logic [2:0]                        req_reg_select,
   input  logic [gpc_pkg::PORT_W-1:0]        req_write_data,
   input  logic [gpc_pkg::PORT_W-1:0]        req_pad_levels,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gpc_pkg::PORT_W-1:0]        rsp_read_data,
   output logic [gpc_pkg::PORT_W-1:0]        rsp_pad_out,
   output logic [gpc_pkg::PORT_W-1:0]        rsp_pad_drive_enable,
   output logic                              rsp_irq_low_half,
   output logic                              rsp_irq_high_half,
   output logic                              rsp_pending_found,
   output logic [gpc_pkg::PIN_IDX_W-1:0]     rsp_first_pending_pin,
   input  logic                              csr_write_enable,
   input  logic [gpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gpc_pkg::PORT_W-1:0]        csr_write_data
);

   logic                              accept;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [gpc_pkg::PORT_W-1:0]        read_data_ff, read_data_in;
   logic [gpc_pkg::PORT_W:0]          found_chain;
   logic [gpc_pkg::PORT_W-1:0]        latch_v, dir_v, data_v, enable_v, status_v;
   logic [gpc_pkg::PORT_W-1:0]        pend_v, first_v;
   logic [gpc_pkg::PIN_IDX_W-1:0]     first_idx;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign found_chain[0] = 1'b0;

   for (genvar p = 0; p < gpc_pkg::PORT_W; p++) begin : g_pin
      if (p < PIN_COUNT) begin : g_cell
         gpc_pkg::pin_req_type  cell_req;
         gpc_pkg::pin_csr_type  cell_csr;
         gpc_pkg::pin_stat_type cell_stat;

         assign cell_req.accept = accept;
         assign cell_req.action = gpc_pkg::action_type'(req_action);
         assign cell_req.sel    = gpc_pkg::reg_sel_type'(req_reg_select);
         assign cell_req.wdata  = req_write_data[p];
         assign cell_req.pad    = req_pad_levels[p];

         assign cell_csr.we        = csr_write_enable;
         assign cell_csr.index     = csr_index;
         assign cell_csr.bit_data  = csr_write_data[p];
         assign cell_csr.mode_data =
            csr_write_data[gpc_pkg::MODE_W*(p % gpc_pkg::HALF_PINS) +: gpc_pkg::MODE_W];

         gpc_pin_cell #(
            .PIN_INDEX (p)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .req       (cell_req),
            .csr       (cell_csr),
            .found_in  (found_chain[p]),
            .found_out (found_chain[p+1]),
            .stat      (cell_stat)
         );

         assign latch_v[p]  = cell_stat.latch;
         assign dir_v[p]    = cell_stat.dir;
         assign data_v[p]   = cell_stat.data_rd;
         assign enable_v[p] = cell_stat.enable;
         assign status_v[p] = cell_stat.status;
         assign pend_v[p]   = cell_stat.pend;
         assign first_v[p]  = cell_stat.is_first;
      end else begin : g_absent
         assign found_chain[p+1] = found_chain[p];
         assign latch_v[p]  = 1'b0;
         assign dir_v[p]    = 1'b0;
         assign data_v[p]   = 1'b0;
         assign enable_v[p] = 1'b0;
         assign status_v[p] = 1'b0;
         assign pend_v[p]   = 1'b0;
         assign first_v[p]  = 1'b0;
      end
   end

   // One-hot to index of the lowest enabled pending pin
   always_comb begin
      first_idx = '0;
      for (int p = 0; p < gpc_pkg::PORT_W; p++) begin
         if (first_v[p]) begin
            first_idx = first_idx | gpc_pkg::PIN_IDX_W'(p);
         end
      end
   end

   // Reads leave the pin state alone, so sample it before the edge
   always_comb begin
      read_data_in = '0;
      if (gpc_pkg::action_type'(req_action) == gpc_pkg::ACT_READ) begin
         case (gpc_pkg::reg_sel_type'(req_reg_select))
            gpc_pkg::SEL_DATA:   read_data_in = data_v;
            gpc_pkg::SEL_IRQ_EN: read_data_in = enable_v;
            gpc_pkg::SEL_STATUS: read_data_in = status_v;
            default:             read_data_in = '0;
         endcase
      end
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_data_ff <= read_data_in;
      end
   end

   // Pin state holds while a response waits, so it drives the response directly
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_data         = read_data_ff;
   assign rsp_pad_out           = latch_v;
   assign rsp_pad_drive_enable  = dir_v;
   assign rsp_irq_low_half      = |pend_v[gpc_pkg::HALF_PINS-1:0];
   assign rsp_irq_high_half     = |pend_v[gpc_pkg::PORT_W-1:gpc_pkg::HALF_PINS];
   assign rsp_pending_found     = found_chain[gpc_pkg::PORT_W];
   assign rsp_first_pending_pin = first_idx;

endmodule

[hdl/gpc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO port checker
// Port-level properties of the pin-interrupt GPIO port, bound to the top.
// ----------------------------------------------------------------------------
module gpc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [1:0]                    req_action,
   input logic [2:0]                    req_reg_select,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [gpc_pkg::PORT_W-1:0]    rsp_read_data,
   input logic                          rsp_irq_low_half,
   input logic                          rsp_irq_high_half,
   input logic                          rsp_pending_found,
   input logic [gpc_pkg::PIN_IDX_W-1:0] rsp_first_pending_pin
);

   a_found_is_or_of_halves: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pending_found == (rsp_irq_low_half | rsp_irq_high_half)))
      else $error("pending_found disagrees with half-port lines");

   a_idle_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_pending_found) |-> (rsp_first_pending_pin == '0))
      else $error("first_pending_pin non-zero with nothing pending");

   a_write_only_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_action == gpc_pkg::ACT_READ &&
       (req_reg_select == gpc_pkg::SEL_SET || req_reg_select == gpc_pkg::SEL_CLEAR ||
        req_reg_select == gpc_pkg::SEL_TOGGLE))
      |=> (rsp_valid && rsp_read_data == '0))
      else $error("read of a write-only register returned data");

   a_held_response: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_read_data)))
      else $error("stalled response changed");

endmodule

bind gpio_port_with_pin_interrupts_top gpc_checker u_gpc_checker (.*);
